>>> hw/rtl/qts_pkg.sv
// shared types, constants and register codes of the quoted token splitter
// no dependencies
package qts_pkg;

   localparam int QTS_SEPARATOR_SLOTS = 4;
   localparam int QTS_SEP_REGS        = 4;
   localparam int QTS_ACTIVE_MAX      = (QTS_SEPARATOR_SLOTS < QTS_SEP_REGS) ?
                                        QTS_SEPARATOR_SLOTS : QTS_SEP_REGS;
   localparam int QTS_CHAR_W          = 8;
   localparam int QTS_COUNT_W         = 3;
   localparam int QTS_CAP_W           = 9;
   localparam int QTS_ADDR_W          = 5;
   localparam int QTS_QUEUE_DEPTH     = 4;
   localparam int QTS_QPTR_W          = $clog2(QTS_QUEUE_DEPTH);
   localparam int QTS_RSP_DATA_W      = 40;

   localparam logic [QTS_CHAR_W-1:0] QTS_QUOTE_CHAR = 8'd34;
   localparam logic [QTS_CHAR_W-1:0] QTS_SPACE_CHAR = 8'd32;

   localparam logic QTS_KIND_CHAR = 1'b0;
   localparam logic QTS_KIND_END  = 1'b1;

   typedef enum logic [2:0] {
      QTS_REG_SEP0     = 3'd0,
      QTS_REG_SEP1     = 3'd1,
      QTS_REG_SEP2     = 3'd2,
      QTS_REG_SEP3     = 3'd3,
      QTS_REG_SEPCOUNT = 3'd4,
      QTS_REG_CAPACITY = 3'd5
   } qts_reg_type;

   typedef struct packed {
      logic [QTS_SEP_REGS-1:0][QTS_CHAR_W-1:0] sep;
      logic [QTS_COUNT_W-1:0]                  sep_count;
      logic [QTS_CHAR_W-1:0]                   keep_limit;
   } qts_cfg_type;

   typedef struct packed {
      logic [QTS_CHAR_W-1:0] ch;
      logic                  eot;
      logic                  is_sep;
      logic                  is_quote;
   } qts_item_type;

endpackage

>>> hw/rtl/qts_csr.sv
// configuration registers on an apb-style port
// depends on qts_pkg
module qts_csr
   import qts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [QTS_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output qts_cfg_type           cfg
);

   logic [QTS_SEP_REGS-1:0][QTS_CHAR_W-1:0] sep_ff, sep_in;
   logic [QTS_COUNT_W-1:0]                  count_ff, count_in;
   logic [QTS_CAP_W-1:0]                    cap_ff, cap_in;
   logic                                    wr_en;
   logic [2:0]                              index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign index      = csr_paddr[4:2];

   always_comb begin
      sep_in   = sep_ff;
      count_in = count_ff;
      cap_in   = cap_ff;
      if (wr_en) begin
         unique case (index)
            QTS_REG_SEP0:     sep_in[0] = csr_pwdata[7:0];
            QTS_REG_SEP1:     sep_in[1] = csr_pwdata[7:0];
            QTS_REG_SEP2:     sep_in[2] = csr_pwdata[7:0];
            QTS_REG_SEP3:     sep_in[3] = csr_pwdata[7:0];
            QTS_REG_SEPCOUNT: count_in  = csr_pwdata[QTS_COUNT_W-1:0];
            QTS_REG_CAPACITY: cap_in    = csr_pwdata[QTS_CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         QTS_REG_SEP0:     csr_prdata = {24'd0, sep_ff[0]};
         QTS_REG_SEP1:     csr_prdata = {24'd0, sep_ff[1]};
         QTS_REG_SEP2:     csr_prdata = {24'd0, sep_ff[2]};
         QTS_REG_SEP3:     csr_prdata = {24'd0, sep_ff[3]};
         QTS_REG_SEPCOUNT: csr_prdata = {{(32-QTS_COUNT_W){1'b0}}, count_ff};
         QTS_REG_CAPACITY: csr_prdata = {{(32-QTS_CAP_W){1'b0}}, cap_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // capacity zero keeps nothing, above 256 acts as 256
   always_comb begin
      cfg.sep       = sep_ff;
      cfg.sep_count = count_ff;
      if (cap_ff == '0) begin
         cfg.keep_limit = '0;
      end else if (cap_ff > QTS_CAP_W'(256)) begin
         cfg.keep_limit = 8'd255;
      end else begin
         cfg.keep_limit = 8'(cap_ff - QTS_CAP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff[0] <= 8'd44;
         sep_ff[1] <= 8'd59;
         sep_ff[2] <= 8'd32;
         sep_ff[3] <= 8'd61;
         count_ff  <= QTS_COUNT_W'(4);
         cap_ff    <= QTS_CAP_W'(20);
      end else begin
         sep_ff   <= sep_in;
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

endmodule

>>> hw/rtl/qts_front.sv
// front end: classifies each incoming character against the separators
// depends on qts_pkg
module qts_front
   import qts_pkg::*;
(
   input  logic [QTS_CHAR_W-1:0] char_in,
   input  logic                  end_of_text,
   input  qts_cfg_type           cfg,
   output qts_item_type          item
);

   logic [QTS_COUNT_W-1:0] active;
   logic                   hit;

   always_comb begin
      if (cfg.sep_count > QTS_COUNT_W'(QTS_ACTIVE_MAX)) begin
         active = QTS_COUNT_W'(QTS_ACTIVE_MAX);
      end else begin
         active = cfg.sep_count;
      end
      hit = 1'b0;
      for (int i = 0; i < QTS_SEP_REGS; i++) begin
         if (i < QTS_ACTIVE_MAX && QTS_COUNT_W'(i) < active && cfg.sep[i] == char_in) begin
            hit = 1'b1;
         end
      end
      item.ch       = char_in;
      item.eot      = end_of_text;
      item.is_sep   = hit;
      item.is_quote = (char_in == QTS_QUOTE_CHAR);
   end

endmodule

>>> hw/rtl/qts_queue.sv
// short queue of classified requests between front and back
// depends on qts_pkg
module qts_queue
   import qts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  qts_item_type push_item,
   output logic         full,
   input  logic         pop,
   output qts_item_type head,
   output logic         empty
);

   qts_item_type               mem_ff [QTS_QUEUE_DEPTH];
   logic [QTS_QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QTS_QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QTS_QPTR_W:0]        count_ff, count_in;
   logic                       do_push, do_pop;

   assign full    = (count_ff == (QTS_QPTR_W+1)'(QTS_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/qts_back.sv
// back end: token state machine and registered result stage
// depends on qts_pkg
module qts_back
   import qts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  qts_cfg_type               cfg,
   input  qts_item_type              head,
   input  logic                      empty,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [QTS_RSP_DATA_W-1:0] rsp_tdata,
   output logic                      rsp_tuser
);

   logic                      phase_ff, phase_in;
   logic                      quoted_ff, quoted_in;
   logic [QTS_CHAR_W-1:0]     kept_ff, kept_in;
   logic [QTS_CHAR_W-1:0]     lead_ff, lead_in;
   logic                      valid_ff, valid_in;
   logic                      kind_ff, kind_in;
   logic [QTS_RSP_DATA_W-1:0] data_ff, data_in;
   logic                      emit;
   logic                      kind;
   logic [QTS_CHAR_W-1:0]     o_char, o_lead, o_trail, o_len;
   logic                      o_found;

   assign pop = ~empty & (~valid_ff | rsp_tready);

   always_comb begin
      phase_in  = phase_ff;
      quoted_in = quoted_ff;
      kept_in   = kept_ff;
      lead_in   = lead_ff;
      emit      = 1'b0;
      kind      = QTS_KIND_CHAR;
      o_char    = '0;
      o_lead    = '0;
      o_trail   = '0;
      o_found   = 1'b0;
      o_len     = '0;
      if (head.eot) begin
         emit      = 1'b1;
         kind      = QTS_KIND_END;
         o_lead    = lead_ff;
         o_found   = (kept_ff != '0);
         o_len     = kept_ff;
         phase_in  = 1'b0;
         quoted_in = 1'b0;
         kept_in   = '0;
         lead_in   = '0;
      end else if (!phase_ff && head.is_sep) begin
         if (lead_ff == '0 || lead_ff == QTS_SPACE_CHAR) begin
            lead_in = head.ch;
         end
      end else if (!quoted_ff && head.is_sep) begin
         // terminating separator becomes the next leading separator
         emit      = 1'b1;
         kind      = QTS_KIND_END;
         o_lead    = lead_ff;
         o_trail   = head.ch;
         o_found   = (kept_ff != '0);
         o_len     = kept_ff;
         phase_in  = 1'b0;
         quoted_in = 1'b0;
         kept_in   = '0;
         lead_in   = head.ch;
      end else if (head.is_quote) begin
         phase_in  = 1'b1;
         quoted_in = ~quoted_ff;
      end else begin
         phase_in = 1'b1;
         if (kept_ff < cfg.keep_limit) begin
            kept_in = kept_ff + 1'b1;
            emit    = 1'b1;
            o_char  = head.ch;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      data_in  = data_ff;
      if (pop && emit) begin
         valid_in = 1'b1;
         kind_in  = kind;
         data_in  = {7'd0, o_len, o_found, o_trail, o_lead, o_char};
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         quoted_ff <= 1'b0;
         kept_ff   <= '0;
         lead_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            phase_ff  <= phase_in;
            quoted_ff <= quoted_in;
            kept_ff   <= kept_in;
            lead_ff   <= lead_in;
         end
      end
   end

endmodule

>>> hw/rtl/quoted_token_splitter_unit.sv
// top level of the quoted token splitter
// depends on qts_pkg, qts_csr, qts_front, qts_queue, qts_back
//
// usage
//   req channel: one request per character, tdata = char_in, tuser =
//   end_of_text. rsp channel: tuser = result_kind (0 token character,
//   1 token end), tdata holds the result fields.
//   csr port: apb-style, separators at 0x00..0x0c, separator count at
//   0x10, token capacity at 0x14; write only while the block is idle.
// path and throughput
//   a request is written into the queue, then its result is registered in
//   the back end's result stage before it shows on rsp. one request per
//   cycle sustained while rsp_tready is high; state updates on each pop.
// reset
//   registers return to their defaults, the queue empties, the token
//   state restarts in the skip phase with no leading separator.
// stalls
//   while rsp_tready is low the back end holds a valid result and the
//   four-entry queue keeps taking requests until it is full.
module quoted_token_splitter_unit
   import qts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // char_in
   input  logic                      req_tuser,  // end_of_text
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // token_char, leading_separator, trailing_separator, token_found,
   // token_length, zero fill
   output logic [QTS_RSP_DATA_W-1:0] rsp_tdata,
   output logic                      rsp_tuser,  // result_kind
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [QTS_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   qts_cfg_type  cfg;
   qts_item_type item;
   qts_item_type head;
   logic         full;
   logic         empty;
   logic         pop;

   assign req_tready = ~full;

   qts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   qts_front u_front (
      .char_in     (req_tdata),
      .end_of_text (req_tuser),
      .cfg         (cfg),
      .item        (item)
   );

   qts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_item (item),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   qts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> bench/testbench.sv
// self-checking bench for quoted_token_splitter_unit: streams characters and end-of-text
// markers through the block, predicts every token result and compares them in order
// depends on qts_pkg and the rtl of quoted_token_splitter_unit
`timescale 1ns / 1ps

module testbench;
   import qts_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 200;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic [7:0] lead;
      logic [7:0] trail;
      logic       found;
      logic [7:0] len;
   } token_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [QTS_RSP_DATA_W-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [QTS_ADDR_W-1:0]     csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // predicted block state and register copy
   logic [7:0]        cfg_sep [QTS_SEP_REGS] = '{8'd44, 8'd59, 8'd32, 8'd61};
   logic [2:0]        cfg_count = 3'd4;
   logic [8:0]        cfg_cap = 9'd20;
   bit                in_token = 1'b0;
   bit                quoted = 1'b0;
   int                kept = 0;
   logic [7:0]        lead_seen = 8'd0;
   token_result_type  expected_results [$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_ask = 0;
   int hold_done = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int requests_sent = 0;
   int chars_seen = 0;
   int ends_seen = 0;
   int input_stalls = 0;
   int settings_used = 0;

   quoted_token_splitter_unit u_top (.*);

   always #2 clock = ~clock;

   // token prediction
   function automatic bit is_separator(input logic [7:0] c);
      int active;
      active = (cfg_count > QTS_ACTIVE_MAX) ? QTS_ACTIVE_MAX : int'(cfg_count);
      for (int i = 0; i < active; i++)
         if (cfg_sep[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int keep_limit();
      int cap;
      cap = cfg_cap;
      if (cap == 0) cap = 1;
      if (cap > 256) cap = 256;
      return cap - 1;
   endfunction

   function automatic void note_leading(input logic [7:0] c);
      if (lead_seen == 8'd0 || lead_seen == QTS_SPACE_CHAR) lead_seen = c;
   endfunction

   function automatic void close_token(input logic [7:0] trail);
      token_result_type r;
      r = '0;
      r.kind  = QTS_KIND_END;
      r.lead  = lead_seen;
      r.trail = trail;
      r.found = (kept != 0);
      r.len   = kept[7:0];
      expected_results.push_back(r);
      in_token  = 1'b0;
      quoted    = 1'b0;
      kept      = 0;
      lead_seen = 8'd0;
   endfunction

   function automatic void advance_splitter(input logic [7:0] c, input logic eot);
      token_result_type r;
      r = '0;
      if (eot) begin
         close_token(8'd0);
         return;
      end
      if (!in_token) begin
         if (is_separator(c)) begin
            note_leading(c);
            return;
         end
         in_token = 1'b1;
      end
      if (!quoted && is_separator(c)) begin
         close_token(c);
         note_leading(c);
         return;
      end
      if (c == QTS_QUOTE_CHAR) begin
         quoted = !quoted;
         return;
      end
      if (kept < keep_limit()) begin
         kept++;
         r.kind = QTS_KIND_CHAR;
         r.ch   = c;
         expected_results.push_back(r);
      end
   endfunction

   // request driver, leaves tvalid high so back-to-back requests stay gapless
   task automatic send_request(input logic [7:0] c, input logic eot);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= eot;
      do @(posedge clock); while (!req_tready);
      advance_splitter(c, eot);
      requests_sent++;
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input qts_reg_type r, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (r) inside
         QTS_REG_SEP0, QTS_REG_SEP1, QTS_REG_SEP2, QTS_REG_SEP3: cfg_sep[r] = v[7:0];
         QTS_REG_SEPCOUNT: cfg_count = v[2:0];
         QTS_REG_CAPACITY: cfg_cap = v[8:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [7:0] s2, input logic [7:0] s3,
                               input int count, input int cap);
      settle_block();
      write_register(QTS_REG_SEP0, 32'(s0));
      write_register(QTS_REG_SEP1, 32'(s1));
      write_register(QTS_REG_SEP2, 32'(s2));
      write_register(QTS_REG_SEP3, 32'(s3));
      write_register(QTS_REG_SEPCOUNT, 32'(count));
      write_register(QTS_REG_CAPACITY, 32'(cap));
      settings_used++;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         1: begin
            sender_idle_pct    = 78;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 78;
         end
         3: begin
            sender_idle_pct    = 17;
            receiver_stall_pct = 17;
         end
         default: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(7))
         0: return ",";
         1: return ";";
         2: return " ";
         3: return "=";
         4: return QTS_QUOTE_CHAR;
         5: return 8'd0;
         6: return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic run_random_text(input int n, input int eot_pct, input int sep_pct,
                                  input int quote_pct);
      int r;
      int active;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         active = (cfg_count > QTS_ACTIVE_MAX) ? QTS_ACTIVE_MAX : int'(cfg_count);
         if (r < eot_pct)
            send_request(8'($urandom_range(255)), 1'b1);
         else if (r < eot_pct + sep_pct && active > 0)
            send_request(cfg_sep[$urandom_range(active - 1)], 1'b0);
         else if (r < eot_pct + sep_pct + quote_pct)
            send_request(QTS_QUOTE_CHAR, 1'b0);
         else if ($urandom_range(1))
            send_request(8'($urandom_range(126, 33)), 1'b0);
         else
            send_request(8'($urandom_range(255)), 1'b0);
      end
   endtask

   // tests
   task automatic test_leading_and_quotes();
      set_idling(0);
      send_request(" ", 1'b0);
      send_request(",", 1'b0);
      send_request(";", 1'b0);
      send_request("A", 1'b0);
      send_request(QTS_QUOTE_CHAR, 1'b0);
      send_request(",", 1'b0);
      send_request(QTS_QUOTE_CHAR, 1'b0);
      send_request(8'hff, 1'b0);
      send_request(8'h00, 1'b0);
      send_request("=", 1'b0);
      send_request("=", 1'b0);
      send_request(8'hff, 1'b1);
      send_request(8'h00, 1'b1);
   endtask

   task automatic test_overflow();
      apply_config(",", ";", " ", "=", 4, 3);
      send_request("a", 1'b0);
      send_request("b", 1'b0);
      send_request("c", 1'b0);
      send_request("d", 1'b0);
      send_request(8'h00, 1'b1);
   endtask

   task automatic test_quote_and_zero_separators();
      send_request("q", 1'b0);
      send_request(QTS_QUOTE_CHAR, 1'b0);
      // quoted mode carries over into a setting where the quote separates
      apply_config(",", ";", 8'd0, QTS_QUOTE_CHAR, 4, 3);
      send_request("r", 1'b0);
      send_request(QTS_QUOTE_CHAR, 1'b0);
      send_request(QTS_QUOTE_CHAR, 1'b0);
      send_request(8'd0, 1'b0);
      send_request("x", 1'b0);
      send_request(8'd0, 1'b0);
      send_request(8'd0, 1'b1);
   endtask

   task automatic test_random_phases();
      int count_plan [10] = '{4, 0, 1, 2, 3, 5, 7, 6, 4, 2};
      int cap_plan [10]   = '{20, 0, 1, 2, 3, 5, 8, 256, 257, 12};
      for (int p = 0; p < 10; p++) begin
         if (p == 0)
            apply_config(",", ";", " ", "=", count_plan[p], cap_plan[p]);
         else
            apply_config(pick_separator(), pick_separator(), pick_separator(),
                         pick_separator(), count_plan[p], cap_plan[p]);
         set_idling(p % 4);
         run_random_text(100, 6, 28, 10);
      end
   endtask

   task automatic test_long_token();
      apply_config(8'hff, 8'd0, QTS_QUOTE_CHAR, " ", 0, 511);
      set_idling(3);
      run_random_text(300, 0, 0, 5);
      send_request(8'h00, 1'b1);
   endtask

   task automatic test_backpressure();
      settle_block();
      set_idling(0);
      hold_ask++;
      for (int i = 0; i < 40; i++) send_request(8'("a" + i % 8), 1'b0);
      send_request(8'h00, 1'b1);
      settle_block();
   endtask

   // sink side, random stalls plus a long hold when a test asks for one
   always @(posedge clock) begin
      if (hold_ask != hold_done) begin
         hold_done = hold_ask;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      token_result_type got;
      token_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind  = rsp_tuser;
         got.ch    = rsp_tdata[7:0];
         got.lead  = rsp_tdata[15:8];
         got.trail = rsp_tdata[23:16];
         got.found = rsp_tdata[24];
         got.len   = rsp_tdata[32:25];
         if (got.kind == QTS_KIND_END) ends_seen++;
         else chars_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result kind %0d char %h lead %h trail %h found %0d len %0d",
                        got.kind, got.ch, got.lead, got.trail, got.found, got.len);
         end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.lead !== want.lead ||
                got.trail !== want.trail || got.found !== want.found ||
                got.len !== want.len) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected kind %0d char %h lead %h trail %h found %0d ",
                            "len %0d, got kind %0d char %h lead %h trail %h found %0d len %0d"},
                           want.kind, want.ch, want.lead, want.trail, want.found, want.len,
                           got.kind, got.ch, got.lead, got.trail, got.found, got.len);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_tvalid && !req_tready) input_stalls <= input_stalls + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_leading_and_quotes();
      test_overflow();
      test_quote_and_zero_separators();
      test_random_phases();
      test_long_token();
      test_backpressure();
      settle_block();
      $display("%0d requests over %0d register settings gave %0d token characters and %0d ends",
               requests_sent, settings_used, chars_seen, ends_seen);
      $display("input held off for %0d cycles while the output was stalled", input_stalls);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/qts_pkg.sv
hw/rtl/qts_csr.sv
hw/rtl/qts_front.sv
hw/rtl/qts_queue.sv
hw/rtl/qts_back.sv
hw/rtl/quoted_token_splitter_unit.sv
bench/testbench.sv
